### hw/rtl/tcw_pkg.sv
package tcw_pkg;

   typedef logic [15:0] cell_type;

   typedef struct packed {
      logic        operation;
      logic [7:0]  char_code;
      logic [10:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [10:0] cursor_position;
      logic [15:0] read_data;
      logic        scrolled;
   } rsp_type;

   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_RETURN    = 8'd13;
   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_SPACE     = 8'd32;
   localparam logic [7:0] RESET_ATTR   = 8'h0F;

   localparam cell_type RESET_CELL = {RESET_ATTR, CH_SPACE};

   // csr register index, taken from paddr[2]
   localparam logic REG_COLOR_ATTRIBUTE = 1'b0;

endpackage

### hw/rtl/text_console_char_writer_unit.sv
// channel  | direction | handshake            | beat
// ---------+-----------+----------------------+------------------------------------
// req      | in        | req_valid/req_stall  | req_type: operation, char, index
// rsp      | out       | rsp_valid/rsp_stall  | rsp_type: cursor, read data, scroll
// csr      | in/out    | psel/penable/pready  | color_attribute at byte address 0
//
// A read or a put that does not scroll is accepted, then the result beat is
// loaded into the output register. A put that scrolls first runs a copy sweep
// through the cell RAM, one cell a cycle, then blanks the bottom row. After
// reset a clearing pass fills the RAM with white spaces; req_stall is high
// during it.
// A result waits in the output register while rsp_stall is high; the next
// item is accepted meanwhile, and its own result waits until the register frees.
module text_console_char_writer_unit
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int LINES   = 25
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int CELLS = COLUMNS * LINES;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(LINES);

   localparam logic [AW-1:0] COLS_A        = AW'(COLUMNS);
   localparam logic [AW-1:0] LAST_CELL     = AW'(CELLS - 1);
   localparam logic [AW-1:0] LAST_ROW_BASE = AW'((LINES - 1) * COLUMNS);
   localparam logic [CW-1:0] LAST_COL      = CW'(COLUMNS - 1);
   localparam logic [RW-1:0] LAST_ROW      = RW'(LINES - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COPY,
      ST_BLANK,
      ST_DONE
   } state_type;

   state_type     state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [AW-1:0] lin_ff, lin_in;
   logic [7:0]    attr_ff, attr_in;

   // write stage: registered, so it writes in the cycle after the issuing state
   logic          wv_ff, wv_in;
   logic [AW-1:0] wa_ff, wa_in;
   cell_type      wd_ff, wd_in;
   logic          wsel_ff, wsel_in;

   logic          res_read_ff, res_read_in;
   logic          res_hit_ff, res_hit_in;
   logic          res_scr_ff, res_scr_in;

   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic          ram_re;
   logic [AW-1:0] ram_raddr;
   cell_type      ram_rdata;
   cell_type      ram_wdata;
   logic          slot_free;
   logic          accept;

   assign ram_wdata = wsel_ff ? ram_rdata : wd_ff;

   tcw_cell_ram #(
      .Depth(CELLS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wv_ff),
      .wr_addr(wa_ff),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // interlock: the write stage must drain before a new item reads the RAM
   assign req_stall = (state_ff != ST_IDLE) || wv_ff;
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_COLOR_ATTRIBUTE) ? {24'd0, attr_ff} : 32'd0;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      lin_in       = lin_ff;
      attr_in      = attr_ff;
      wv_in        = 1'b0;
      wa_in        = wa_ff;
      wd_in        = wd_ff;
      wsel_in      = 1'b0;
      res_read_in  = res_read_ff;
      res_hit_in   = res_hit_ff;
      res_scr_in   = res_scr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_re       = 1'b0;
      ram_raddr    = cnt_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (psel && penable && pwrite && (paddr[2] == REG_COLOR_ATTRIBUTE)) begin
         attr_in = pwdata[7:0];
      end

      case (state_ff)
         ST_CLEAR: begin
            wv_in = 1'b1;
            wa_in = cnt_ff;
            wd_in = RESET_CELL;
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               res_read_in = (req_data.operation == OP_READ);
               res_hit_in  = 32'(req_data.cell_index) < 32'(CELLS);
               res_scr_in  = 1'b0;
               state_in    = ST_DONE;
               if (req_data.operation == OP_READ) begin
                  ram_re    = 1'b1;
                  ram_raddr = AW'(req_data.cell_index);
               end else begin
                  case (req_data.char_code)
                     CH_NEWLINE: begin
                        col_in = '0;
                        if (row_ff == LAST_ROW) begin
                           res_scr_in = 1'b1;
                        end else begin
                           row_in = row_ff + 1'b1;
                           lin_in = lin_ff - AW'(col_ff) + COLS_A;
                        end
                     end
                     CH_RETURN: begin
                        col_in = '0;
                        lin_in = lin_ff - AW'(col_ff);
                     end
                     CH_BACKSPACE: begin
                        if (col_ff != '0) begin
                           col_in = col_ff - 1'b1;
                           lin_in = lin_ff - 1'b1;
                           wv_in  = 1'b1;
                           wa_in  = lin_ff - 1'b1;
                           wd_in  = {attr_ff, CH_SPACE};
                        end
                     end
                     default: begin
                        wv_in = 1'b1;
                        wa_in = lin_ff;
                        wd_in = {attr_ff, req_data.char_code};
                        if (col_ff == LAST_COL) begin
                           col_in = '0;
                           if (row_ff == LAST_ROW) begin
                              res_scr_in = 1'b1;
                           end else begin
                              row_in = row_ff + 1'b1;
                              lin_in = lin_ff + 1'b1;
                           end
                        end else begin
                           col_in = col_ff + 1'b1;
                           lin_in = lin_ff + 1'b1;
                        end
                     end
                  endcase
                  if (res_scr_in) begin
                     row_in   = LAST_ROW;
                     lin_in   = LAST_ROW_BASE;
                     cnt_in   = COLS_A;
                     state_in = ST_COPY;
                  end
               end
            end
         end

         ST_COPY: begin
            // read one row ahead, write the beat back one row up next cycle
            ram_re    = 1'b1;
            ram_raddr = cnt_ff;
            wv_in     = 1'b1;
            wa_in     = cnt_ff - COLS_A;
            wsel_in   = 1'b1;
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = LAST_ROW_BASE;
               state_in = ST_BLANK;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ST_BLANK: begin
            wv_in = 1'b1;
            wa_in = cnt_ff;
            wd_in = {attr_ff, CH_SPACE};
            if (cnt_ff == LAST_CELL) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.cursor_position = 11'(lin_ff);
               rsp_data_in.read_data       = (res_read_ff && res_hit_ff) ? ram_rdata : 16'd0;
               rsp_data_in.scrolled        = res_scr_ff;
               state_in                    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         lin_ff       <= '0;
         attr_ff      <= RESET_ATTR;
         wv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         lin_ff       <= lin_in;
         attr_ff      <= attr_in;
         wv_ff        <= wv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      wa_ff       <= wa_in;
      wd_ff       <= wd_in;
      wsel_ff     <= wsel_in;
      res_read_ff <= res_read_in;
      res_hit_ff  <= res_hit_in;
      res_scr_ff  <= res_scr_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### hw/rtl/tcw_cell_ram.sv
module tcw_cell_ram
   import tcw_pkg::*;
#(
   parameter int Depth = 2000,
   localparam int AddrBits = $clog2(Depth)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AddrBits-1:0] wr_addr,
   input  cell_type            wr_data,
   input  logic                rd_en,
   input  logic [AddrBits-1:0] rd_addr,
   output cell_type            rd_data
);

   cell_type mem [Depth];
   cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### tb/sv/tb_text_console_char_writer_unit.sv
module tb_text_console_char_writer_unit;
   import tcw_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLUMNS    = 80;
   localparam int LINES      = 25;
   localparam int CELL_COUNT = COLUMNS * LINES;
   localparam int PHASE_ITEMS = 375;
   localparam int unsigned CYCLE_LIMIT = 13_000_000;
   localparam logic [2:0] ATTR_ADDR = {REG_COLOR_ATTRIBUTE, 2'b00};

   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type want;
   } dir_row_t;

   // rows with typed = 1 carry their expected beat, the rest go through the predictor
   localparam dir_row_t DIRECTED [18] = '{
      '{'{OP_READ, 8'h00, 11'd0},          1'b1, '{11'd0, RESET_CELL, 1'b0}},
      '{'{OP_READ, 8'h00, 11'd1999},       1'b1, '{11'd0, RESET_CELL, 1'b0}},
      '{'{OP_READ, 8'hFF, 11'd2000},       1'b1, '{11'd0, 16'h0000, 1'b0}},
      '{'{OP_READ, 8'h00, 11'h7FF},        1'b1, '{11'd0, 16'h0000, 1'b0}},
      '{'{OP_PUT, CH_BACKSPACE, 11'd0},    1'b1, '{11'd0, 16'h0000, 1'b0}},
      '{'{OP_PUT, CH_RETURN, 11'd0},       1'b1, '{11'd0, 16'h0000, 1'b0}},
      '{'{OP_PUT, 8'h41, 11'd0},           1'b1, '{11'd1, 16'h0000, 1'b0}},
      '{'{OP_PUT, 8'hFF, 11'h7FF},         1'b1, '{11'd2, 16'h0000, 1'b0}},
      '{'{OP_PUT, 8'h00, 11'd0},           1'b1, '{11'd3, 16'h0000, 1'b0}},
      '{'{OP_READ, 8'h00, 11'd0},          1'b0, '0},
      '{'{OP_READ, 8'h00, 11'd2},          1'b0, '0},
      '{'{OP_PUT, CH_BACKSPACE, 11'd0},    1'b0, '0},
      '{'{OP_READ, 8'h00, 11'd2},          1'b0, '0},
      '{'{OP_PUT, CH_NEWLINE, 11'd0},      1'b0, '0},
      '{'{OP_PUT, 8'h7F, 11'h7FF},         1'b0, '0},
      '{'{OP_READ, 8'hFF, 11'd80},         1'b0, '0},
      '{'{OP_PUT, CH_RETURN, 11'h555},     1'b0, '0},
      '{'{OP_PUT, CH_NEWLINE, 11'h2AA},    1'b0, '0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   text_console_char_writer_unit #(
      .COLUMNS(COLUMNS),
      .LINES  (LINES)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // predicted console state
   logic [15:0] screen_model [0:CELL_COUNT-1];
   int          cur_row;
   int          cur_col;
   logic [7:0]  color_attr;

   rsp_type     console_replies [$];
   int          err_count = 0;
   int unsigned cycle_count = 0;
   logic        calm = 1'b0;

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_text_console_char_writer_unit: errors");
         $finish;
      end
   end

   task automatic report_mismatch(string what, int got, int want);
      if (err_count < 100)
         $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
      err_count++;
   endtask

   task automatic console_reset();
      for (int i = 0; i < CELL_COUNT; i++)
         screen_model[i] = RESET_CELL;
      cur_row    = 0;
      cur_col    = 0;
      color_attr = RESET_ATTR;
   endtask

   // column 0 of next row; scroll when leaving the bottom row
   task automatic advance_line(output logic scroll_now);
      cur_col = 0;
      cur_row++;
      scroll_now = 1'b0;
      if (cur_row >= LINES) begin
         for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
            screen_model[i] = screen_model[i + COLUMNS];
         for (int c = 0; c < COLUMNS; c++)
            screen_model[(LINES - 1) * COLUMNS + c] = {color_attr, CH_SPACE};
         cur_row    = LINES - 1;
         scroll_now = 1'b1;
      end
   endtask

   task automatic console_apply(input req_type item, output rsp_type reply);
      logic scroll_now;
      scroll_now = 1'b0;
      reply = '0;
      if (item.operation == OP_READ) begin
         if (item.cell_index < CELL_COUNT)
            reply.read_data = screen_model[item.cell_index];
      end else if (item.char_code == CH_NEWLINE) begin
         advance_line(scroll_now);
      end else if (item.char_code == CH_RETURN) begin
         cur_col = 0;
      end else if (item.char_code == CH_BACKSPACE) begin
         if (cur_col > 0) begin
            cur_col--;
            screen_model[cur_row * COLUMNS + cur_col] = {color_attr, CH_SPACE};
         end
      end else begin
         screen_model[cur_row * COLUMNS + cur_col] = {color_attr, item.char_code};
         cur_col++;
         if (cur_col >= COLUMNS)
            advance_line(scroll_now);
      end
      reply.cursor_position = 11'(cur_row * COLUMNS + cur_col);
      reply.scrolled        = scroll_now;
   endtask

   // called at a falling edge, returns at a falling edge after the beat is taken
   task automatic send_beat(req_type item, logic typed, rsp_type want);
      rsp_type predicted;
      while (!calm && $urandom_range(0, 99) < 36) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      console_apply(item, predicted);
      console_replies.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [7:0] value);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= ATTR_ADDR;
      pwdata  <= {24'b0, value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      color_attr = value;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_check(logic [7:0] want);
      logic [7:0] got;
      psel    <= 1'b1;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      paddr   <= ATTR_ADDR;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata[7:0];
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== want)
         report_mismatch("color_attribute readback", got, want);
   endtask

   // mostly text with line control; long_lines mode reaches the row wrap
   function automatic req_type pick_item(logic long_lines);
      req_type item;
      int      p;
      int      base;
      item.operation  = OP_PUT;
      item.char_code  = 8'($urandom_range(0, 255));
      item.cell_index = 11'($urandom_range(0, 2047));
      p = $urandom_range(0, 99);
      if (p < (long_lines ? 10 : 35)) begin
         item.operation = OP_READ;
         p = $urandom_range(0, 99);
         if (p < 25) begin
            base = cur_row * COLUMNS + cur_col - $urandom_range(0, 4);
            item.cell_index = 11'(base < 0 ? 0 : base);
         end else if (p < 45) begin
            item.cell_index = 11'($urandom_range((LINES - 2) * COLUMNS, CELL_COUNT - 1));
         end else if (p < 85) begin
            item.cell_index = 11'($urandom_range(0, CELL_COUNT - 1));
         end
      end else begin
         p = $urandom_range(0, 99);
         if (long_lines) begin
            if (p < 1)
               item.char_code = CH_NEWLINE;
            else if (p < 3)
               item.char_code = CH_BACKSPACE;
         end else begin
            if (p < 8)
               item.char_code = CH_NEWLINE;
            else if (p < 11)
               item.char_code = CH_RETURN;
            else if (p < 19)
               item.char_code = CH_BACKSPACE;
         end
      end
      return item;
   endfunction

   task automatic wait_drained();
      while (console_replies.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 36);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (console_replies.size() == 0) begin
            report_mismatch("beat with nothing pending", rsp_data, 0);
         end else begin
            want = console_replies.pop_front();
            if (rsp_data.cursor_position !== want.cursor_position)
               report_mismatch("cursor_position", rsp_data.cursor_position,
                               want.cursor_position);
            if (rsp_data.read_data !== want.read_data)
               report_mismatch("read_data", rsp_data.read_data, want.read_data);
            if (rsp_data.scrolled !== want.scrolled)
               report_mismatch("scrolled", rsp_data.scrolled, want.scrolled);
         end
      end
   end

   initial begin
      logic [7:0] phase_attr [4];
      phase_attr[0] = 8'hFF;
      phase_attr[1] = 8'h00;
      phase_attr[2] = 8'($urandom_range(0, 255));
      phase_attr[3] = 8'h5A;
      console_reset();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // clearing pass after reset holds off the request channel
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      csr_check(RESET_ATTR);

      foreach (DIRECTED[i])
         send_beat(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);

      for (int ph = 0; ph < 4; ph++) begin
         req_valid <= 1'b0;
         wait_drained();
         csr_write(phase_attr[ph]);
         @(negedge clock);
         csr_check(phase_attr[ph]);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            calm = (ph == 2) && (k < 200);
            send_beat(pick_item(((k / 60) % 3) == 2), 1'b0, '0);
         end
         calm = 1'b0;
      end
      req_valid <= 1'b0;

      while (console_replies.size() != 0) @(posedge clock);
      repeat (2100) @(posedge clock);
      if (err_count == 0 && console_replies.size() == 0) begin
         $display("tb_text_console_char_writer_unit: clean");
      end else begin
         $display("tb_text_console_char_writer_unit: errors");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_cell_ram.sv
hw/rtl/text_console_char_writer_unit.sv
tb/sv/tb_text_console_char_writer_unit.sv
